FILE: src/delayed_audio_position_tracker_unit_assert.svh
// Assertion macros used by the tracker control FSM.
`ifndef DELAYED_AUDIO_POSITION_TRACKER_UNIT_ASSERT_SVH
`define DELAYED_AUDIO_POSITION_TRACKER_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define DAPT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset.
`define DAPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/dapt_pkg.sv
package dapt_pkg;

    localparam int SAMPLE_RATE     = 44100;
    localparam int BLOCK_ALIGN     = 4;
    localparam int RING_BYTES      = 1048576;
    localparam int MAX_STEP_FRAMES = 4096;

    localparam int SR_W    = $clog2(SAMPLE_RATE + 1);
    localparam int MAX_W   = $clog2(MAX_STEP_FRAMES + 1);
    localparam int DIV_QB  = (SR_W > MAX_W) ? SR_W : MAX_W;
    localparam int BA_QB   = $clog2(BLOCK_ALIGN);
    localparam int RING_W  = $clog2(RING_BYTES);
    localparam int BYTES_W = $clog2(MAX_STEP_FRAMES * BLOCK_ALIGN + 1);
    localparam int LIM_W   = 32 + MAX_W;
    localparam int PROD_W  = 32 + SR_W;
    localparam int FRM_W   = DIV_QB + SR_W + 1;
    localparam int MOD_STEPS = 63;

    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 192;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_FREQ = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LATENCY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTIFY_EN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DMA_BYTES = 3'd4;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_PAUSE = 2'd2,
        OP_STOP  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        DIV_Q1    = 3'd0,
        DIV_Q2    = 3'd1,
        DIV_LNP   = 3'd2,
        DIV_SRC   = 3'd3,
        DIV_SRCBA = 3'd4
    } div_sel_t;

    typedef struct packed {
        logic     take;
        logic     decode;
        logic     limit;
        logic     sat_chk;
        logic     div_start;
        div_sel_t div_sel;
        logic     mul;
        logic     frm;
        logic     pos;
        logic     play;
        logic     bnd;
        logic     note;
        logic     seg_init;
        logic     len;
        logic     out_fire;
        logic     out_zero;
    } dapt_cmd_t;

    typedef struct packed {
        logic go_tick;
        logic sat;
        logic div_busy;
        logic frames_zero;
        logic notify_on;
        logic seg_last;
    } dapt_stat_t;

endpackage

FILE: src/dapt_div.sv
module dapt_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] den,
    input  logic [31:0] rem_init,
    input  logic [63:0] num_init,
    input  logic [6:0]  steps,
    output logic        busy,
    output logic [63:0] quot,
    output logic [31:0] rem
);

    logic [6:0]  cnt_reg;
    logic [31:0] den_reg;
    logic [31:0] rem_reg;
    logic [63:0] num_reg;
    logic [32:0] trial;
    logic        ge;

    // restoring step: one quotient bit per cycle
    assign trial = {rem_reg, num_reg[63]};
    assign ge    = trial >= {1'b0, den_reg};
    assign busy  = cnt_reg != 7'd0;
    assign quot  = num_reg;
    assign rem   = rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 7'd0;
        end else if (start) begin
            cnt_reg <= steps;
        end else if (busy) begin
            cnt_reg <= cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= den;
            rem_reg <= rem_init;
            num_reg <= num_init;
        end else if (busy) begin
            rem_reg <= ge ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
            num_reg <= {num_reg[62:0], ge};
        end
    end

endmodule

FILE: src/dapt_ctrl.sv
`include "delayed_audio_position_tracker_unit_assert.svh"

module dapt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  dapt_pkg::dapt_stat_t st,
    output dapt_pkg::dapt_cmd_t  cmd
);

    typedef enum logic [23:0] {
        S_IDLE   = 24'h000001,
        S_DECODE = 24'h000002,
        S_LIMIT  = 24'h000004,
        S_SAT    = 24'h000008,
        S_D1     = 24'h000010,
        S_W1     = 24'h000020,
        S_MUL    = 24'h000040,
        S_D2     = 24'h000080,
        S_W2     = 24'h000100,
        S_FRM    = 24'h000200,
        S_POS    = 24'h000400,
        S_PLAY   = 24'h000800,
        S_D3     = 24'h001000,
        S_W3     = 24'h002000,
        S_BND    = 24'h004000,
        S_NOTE   = 24'h008000,
        S_D4     = 24'h010000,
        S_W4     = 24'h020000,
        S_D5     = 24'h040000,
        S_W5     = 24'h080000,
        S_SEGI   = 24'h100000,
        S_LEN    = 24'h200000,
        S_OUT    = 24'h400000,
        S_EMIT   = 24'h800000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = dapt_pkg::DIV_Q1;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.decode = 1'b1;
                state_next = st.go_tick ? S_LIMIT : S_EMIT;
            end
            S_LIMIT: begin
                cmd.limit  = 1'b1;
                state_next = S_SAT;
            end
            S_SAT: begin
                cmd.sat_chk = 1'b1;
                state_next  = st.sat ? S_POS : S_D1;
            end
            S_D1: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = dapt_pkg::DIV_Q1;
                state_next    = S_W1;
            end
            S_W1: begin
                if (!st.div_busy) state_next = S_MUL;
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_D2;
            end
            S_D2: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = dapt_pkg::DIV_Q2;
                state_next    = S_W2;
            end
            S_W2: begin
                if (!st.div_busy) state_next = S_FRM;
            end
            S_FRM: begin
                cmd.frm    = 1'b1;
                state_next = S_POS;
            end
            S_POS: begin
                cmd.pos    = 1'b1;
                state_next = st.frames_zero ? S_EMIT : S_PLAY;
            end
            S_PLAY: begin
                cmd.play   = 1'b1;
                state_next = st.notify_on ? S_D3 : S_D4;
            end
            S_D3: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = dapt_pkg::DIV_LNP;
                state_next    = S_W3;
            end
            S_W3: begin
                if (!st.div_busy) state_next = S_BND;
            end
            S_BND: begin
                cmd.bnd    = 1'b1;
                state_next = S_NOTE;
            end
            S_NOTE: begin
                cmd.note   = 1'b1;
                state_next = S_D4;
            end
            S_D4: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = dapt_pkg::DIV_SRC;
                state_next    = S_W4;
            end
            S_W4: begin
                if (!st.div_busy) state_next = S_D5;
            end
            S_D5: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = dapt_pkg::DIV_SRCBA;
                state_next    = S_W5;
            end
            S_W5: begin
                if (!st.div_busy) state_next = S_SEGI;
            end
            S_SEGI: begin
                cmd.seg_init = 1'b1;
                state_next   = S_LEN;
            end
            S_LEN: begin
                cmd.len    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    cmd.out_fire = 1'b1;
                    state_next   = st.seg_last ? S_IDLE : S_LEN;
                end
            end
            S_EMIT: begin
                m_tvalid     = 1'b1;
                cmd.out_zero = 1'b1;
                if (m_tready) state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    `DAPT_ASSERT_NOW(a_no_overlap, s_tready, !m_tvalid, "input taken while a result is pending")
    `DAPT_ASSERT_NEXT(a_take_decode, s_tvalid && s_tready, state_reg == S_DECODE, "accepted item not decoded")
    `DAPT_ASSERT_NOW(a_div_idle, cmd.div_start, !st.div_busy, "divider restarted while busy")
    `DAPT_ASSERT_NEXT(a_last_idle, m_tvalid && m_tready && (st.seg_last || cmd.out_zero), s_tready, "no return to idle after final result")

endmodule

FILE: src/dapt_dp.sv
module dapt_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [dapt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dapt_pkg::CFG_W-1:0]           cfg_data,
    input  logic [dapt_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic [1:0]                           s_tuser,
    output logic [dapt_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                 m_tlast,
    input  dapt_pkg::dapt_cmd_t                  cmd,
    output dapt_pkg::dapt_stat_t                 st
);

    localparam int RW = dapt_pkg::RING_W;
    localparam int BW = dapt_pkg::BYTES_W;

    // configuration
    logic [31:0] tf_reg;
    logic [23:0] lat_reg;
    logic [23:0] per_reg;
    logic        ne_reg;
    logic [28:0] dma_reg;

    // item and tracking state
    logic [1:0]  op_reg;
    logic [62:0] now_reg;
    logic        running_reg;
    logic [62:0] last_cnt_reg;
    logic [62:0] cons_reg;
    logic [62:0] play_reg;
    logic [62:0] lnp_reg;

    // work registers
    logic [62:0]                      delta_reg;
    logic [dapt_pkg::LIM_W-1:0]       lim_reg;
    logic [dapt_pkg::DIV_QB-1:0]      q1_reg;
    logic [dapt_pkg::PROD_W-1:0]      prod_reg;
    logic [dapt_pkg::MAX_W-1:0]       frames_reg;
    logic [62:0]                      prev_reg;
    logic [63:0]                      bnd_reg;
    logic                             notify_reg;
    logic [27:0]                      src_reg;
    logic [RW-1:0]                    dst_reg;
    logic [BW-1:0]                    left_reg;
    logic [BW-1:0]                    len_reg;
    logic [1:0]                       k_reg;

    // divider
    logic [63:0] n64;
    logic [31:0] div_den;
    logic [6:0]  div_steps;
    logic        div_busy;
    logic [63:0] div_quot;
    logic [31:0] div_rem;

    logic [dapt_pkg::FRM_W-1:0] frm_sum;
    logic [63:0]                dst_prod;
    logic [31:0]                len_a, len_b, len_c, len_ab;
    logic [28:0]                src_sum;
    logic [RW:0]                dst_sum;

    always_comb begin
        case (cmd.div_sel)
            dapt_pkg::DIV_Q1: begin
                n64 = {1'b0, delta_reg};
                div_den = tf_reg;
                div_steps = 7'(dapt_pkg::DIV_QB);
            end
            dapt_pkg::DIV_Q2: begin
                n64 = 64'(prod_reg);
                div_den = tf_reg;
                div_steps = 7'(dapt_pkg::DIV_QB);
            end
            dapt_pkg::DIV_LNP: begin
                n64 = {1'b0, lnp_reg};
                div_den = 32'(per_reg);
                div_steps = 7'(dapt_pkg::MOD_STEPS);
            end
            dapt_pkg::DIV_SRC: begin
                n64 = {1'b0, prev_reg};
                div_den = 32'(dma_reg);
                div_steps = 7'(dapt_pkg::MOD_STEPS);
            end
            dapt_pkg::DIV_SRCBA: begin
                n64 = 64'(div_rem) * 64'(dapt_pkg::BLOCK_ALIGN);
                div_den = 32'(dma_reg);
                div_steps = 7'(dapt_pkg::BA_QB);
            end
            default: begin
                n64 = 64'd0;
                div_den = 32'd0;
                div_steps = 7'd0;
            end
        endcase
    end

    dapt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .den      (div_den),
        .rem_init (32'(n64 >> div_steps)),
        .num_init (n64 << (7'd64 - div_steps)),
        .steps    (div_steps),
        .busy     (div_busy),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    assign frm_sum = dapt_pkg::FRM_W'(q1_reg) * dapt_pkg::FRM_W'(dapt_pkg::SAMPLE_RATE)
                   + dapt_pkg::FRM_W'(div_quot[dapt_pkg::DIV_QB-1:0]);
    assign dst_prod = 64'(prev_reg[RW-1:0]) * 64'(dapt_pkg::BLOCK_ALIGN);
    assign len_a  = 32'(left_reg);
    assign len_b  = 32'(dma_reg) - 32'(src_reg);
    assign len_c  = 32'(dapt_pkg::RING_BYTES) - 32'(dst_reg);
    assign len_ab = (len_a < len_b) ? len_a : len_b;
    assign src_sum = 29'(src_reg) + 29'(len_reg);
    assign dst_sum = (RW+1)'(dst_reg) + (RW+1)'(len_reg);

    assign st.go_tick = (op_reg == dapt_pkg::OP_TICK) && running_reg && (dma_reg != 29'd0)
                        && (now_reg > last_cnt_reg) && (tf_reg != 32'd0);
    assign st.sat         = 64'(delta_reg) >= 64'(lim_reg);
    assign st.div_busy    = div_busy;
    assign st.frames_zero = frames_reg == '0;
    assign st.notify_on   = (per_reg != 24'd0) && ne_reg;
    assign st.seg_last    = (left_reg == len_reg) || (k_reg == 2'd2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tf_reg  <= 32'd10000000;
            lat_reg <= 24'd0;
            per_reg <= 24'd0;
            ne_reg  <= 1'b0;
            dma_reg <= 29'd708608;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                dapt_pkg::CFG_TICK_FREQ: tf_reg  <= cfg_data;
                dapt_pkg::CFG_LATENCY:   lat_reg <= cfg_data[23:0];
                dapt_pkg::CFG_PERIOD:    per_reg <= cfg_data[23:0];
                dapt_pkg::CFG_NOTIFY_EN: ne_reg  <= cfg_data[0];
                dapt_pkg::CFG_DMA_BYTES: dma_reg <= cfg_data[28:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg  <= 1'b0;
            last_cnt_reg <= 63'd0;
            cons_reg     <= 63'd0;
            play_reg     <= 63'd0;
            lnp_reg      <= 63'd0;
            notify_reg   <= 1'b0;
        end else begin
            if (cmd.decode) begin
                notify_reg <= 1'b0;
                case (op_reg)
                    dapt_pkg::OP_START: begin
                        if (!running_reg) begin
                            running_reg  <= 1'b1;
                            last_cnt_reg <= now_reg;
                            lnp_reg      <= 63'd0;
                        end
                    end
                    dapt_pkg::OP_PAUSE: running_reg <= 1'b0;
                    dapt_pkg::OP_STOP: begin
                        running_reg <= 1'b0;
                        cons_reg    <= 63'd0;
                        play_reg    <= 63'd0;
                        lnp_reg     <= 63'd0;
                    end
                    default: begin
                        if (running_reg && dma_reg != 29'd0) last_cnt_reg <= now_reg;
                    end
                endcase
            end
            if (cmd.pos && frames_reg != '0) begin
                cons_reg <= cons_reg + 63'(frames_reg);
            end
            if (cmd.play) begin
                play_reg <= (cons_reg > 63'(lat_reg)) ? cons_reg - 63'(lat_reg) : 63'd0;
            end
            if (cmd.note && ({1'b0, play_reg} >= bnd_reg)) begin
                notify_reg <= 1'b1;
                lnp_reg    <= play_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            op_reg  <= s_tuser;
            now_reg <= s_tdata[62:0];
        end
        if (cmd.decode) delta_reg <= now_reg - last_cnt_reg;
        if (cmd.limit) begin
            lim_reg <= dapt_pkg::LIM_W'(tf_reg) * dapt_pkg::LIM_W'(dapt_pkg::MAX_STEP_FRAMES);
        end
        if (cmd.sat_chk) frames_reg <= dapt_pkg::MAX_W'(dapt_pkg::MAX_STEP_FRAMES);
        if (cmd.mul) begin
            q1_reg   <= div_quot[dapt_pkg::DIV_QB-1:0];
            prod_reg <= dapt_pkg::PROD_W'(div_rem) * dapt_pkg::PROD_W'(dapt_pkg::SAMPLE_RATE);
        end
        if (cmd.frm) begin
            frames_reg <= (frm_sum > dapt_pkg::FRM_W'(dapt_pkg::MAX_STEP_FRAMES))
                        ? dapt_pkg::MAX_W'(dapt_pkg::MAX_STEP_FRAMES)
                        : dapt_pkg::MAX_W'(frm_sum);
        end
        if (cmd.pos) prev_reg <= cons_reg;
        if (cmd.bnd) bnd_reg <= {1'b0, lnp_reg} - 64'(div_rem) + 64'(per_reg);
        if (cmd.seg_init) begin
            src_reg  <= div_rem[27:0];
            dst_reg  <= dst_prod[RW-1:0];
            left_reg <= BW'(32'(frames_reg) * 32'(dapt_pkg::BLOCK_ALIGN));
            k_reg    <= 2'd0;
        end
        if (cmd.len) len_reg <= BW'((len_ab < len_c) ? len_ab : len_c);
        if (cmd.out_fire) begin
            left_reg <= left_reg - len_reg;
            k_reg    <= k_reg + 2'd1;
            src_reg  <= (src_sum == dma_reg) ? 28'd0 : src_sum[27:0];
            dst_reg  <= dst_sum[RW-1:0];
        end
    end

    assign m_tdata = {2'b00,
                      cmd.out_zero ? 15'd0 : 15'(len_reg),
                      cmd.out_zero ? 20'd0 : 20'(dst_reg),
                      cmd.out_zero ? 28'd0 : src_reg,
                      notify_reg, play_reg, cons_reg};
    assign m_tlast = cmd.out_zero || st.seg_last;

endmodule

FILE: src/delayed_audio_position_tracker_unit.sv
// Delayed audio position tracker.
// Input channel (s_*): one transaction per command; s_tuser carries the operation
// (tick, start, pause, stop), s_tdata the 63-bit counter value.
// Output channel (m_*): one to three result transactions per command, m_tlast on
// the final one. Each carries both positions, the notify flag and one copy segment.
// Configuration: cfg_wr_en/cfg_index/cfg_data write one register per cycle;
// write only while the block is idle.
// Commands are handled one at a time; s_tready is high only while idle.
// Start, pause, stop and inactive ticks: decoded, then one zero-segment result.
// Active tick: all divisions run on one shared restoring divider, one bit a cycle:
// two frame divisions of DIV_QB steps (16 by default) and two 63-step modulos
// (the period modulo only with notifications on), plus a short one for the block
// alignment; after the first result, each further segment passes through a length
// state and an output state. A saturated step skips the frame divisions.
// A stalled receiver holds the current result; nothing is dropped.
// Reset restores the register defaults, stops the stream and clears positions.
module delayed_audio_position_tracker_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // [62:0] counter_now
    input  logic [1:0]   s_tuser,   // [1:0] operation
    output logic         m_tvalid,
    input  logic         m_tready,
    // [62:0] consumed_frames, [125:63] played_frames, [126] notify,
    // [154:127] copy_src_offset, [174:155] copy_dst_offset, [189:175] copy_bytes
    output logic [191:0] m_tdata,
    output logic         m_tlast
);

    dapt_pkg::dapt_cmd_t  cmd;
    dapt_pkg::dapt_stat_t st;

    dapt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    dapt_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .st        (st)
    );

endmodule
